### sv/binary_heap_priority_queue_assert.svh
// ----------------------------------------------------------------------------
// Binary heap priority queue assertion macros
// Shorthand for the concurrent checks used inside the heap RTL.
// ----------------------------------------------------------------------------
`ifndef BINARY_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BHPQ_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("bhpq: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BHPQ_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("bhpq: next-cycle check failed");

`endif

### sv/bhpq_pkg.sv
// ----------------------------------------------------------------------------
// Binary heap priority queue package
// Widths, status codes and the controller-to-datapath command and status types.
// ----------------------------------------------------------------------------
package bhpq_pkg;

    localparam int DEFAULT_CAPACITY = 64;
    localparam int VALUE_W          = 32;
    localparam int COUNT_W          = 7;
    localparam int STATUS_W         = 2;
    localparam logic RESET_MAX_MODE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Which address the first memory read port looks at.
    typedef enum logic [1:0] {
        RD_LAST,
        RD_PARENT,
        RD_CHILD
    } rd_sel_t;

    typedef struct packed {
        logic    start_push;
        logic    start_pop;
        logic    load_last;
        logic    up_move;
        logic    dn_move;
        logic    place;
        logic    load_result;
        rd_sel_t rd_sel;
        status_t res_status;
    } bhpq_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic idx_zero;
        logic up_win;
        logic dn_leaf;
        logic dn_win;
    } bhpq_stat_t;

endpackage

### sv/binary_heap_priority_queue.sv
// One item at a time: a new push or pop is accepted only in the idle state, after the
// previous result is loaded; rejected items go straight to the result. Each heap level
// is one memory read and then one compare-and-move through the single write port.
// Reset (aresetn, synchronous, active low) empties the heap and selects max-heap order;
// the heap memory itself is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// Binary heap priority queue
// Push and pop on a fixed-capacity heap with selectable max or min ordering.
// ----------------------------------------------------------------------------
module binary_heap_priority_queue #(
    parameter int CAPACITY = bhpq_pkg::DEFAULT_CAPACITY
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic                                cfg_max_mode,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_op,
    input  logic signed [bhpq_pkg::VALUE_W-1:0] s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [bhpq_pkg::STATUS_W-1:0]       m_status,
    output logic signed [bhpq_pkg::VALUE_W-1:0] m_top_value,
    output logic                                m_top_valid,
    output logic [bhpq_pkg::COUNT_W-1:0]        m_count
);
    import bhpq_pkg::*;

    bhpq_cmd_t  cmd;
    bhpq_stat_t stat;

    // The mode register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    bhpq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_op    (s_op),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat_i  (stat),
        .cmd_o   (cmd)
    );

    bhpq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_max_mode (cfg_max_mode),
        .s_value      (s_value),
        .cmd_i        (cmd),
        .stat_o       (stat),
        .m_status     (m_status),
        .m_top_value  (m_top_value),
        .m_top_valid  (m_top_valid),
        .m_count      (m_count)
    );

endmodule

### sv/bhpq_datapath.sv
// ----------------------------------------------------------------------------
// Binary heap datapath
// Heap memory, element count, sift index, moving element, root copy and the
// result register.
// ----------------------------------------------------------------------------
`include "binary_heap_priority_queue_assert.svh"

module bhpq_datapath #(
    parameter int CAPACITY = bhpq_pkg::DEFAULT_CAPACITY
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_valid,
    input  logic                                   cfg_max_mode,
    input  logic signed [bhpq_pkg::VALUE_W-1:0]    s_value,
    input  bhpq_pkg::bhpq_cmd_t                    cmd_i,
    output bhpq_pkg::bhpq_stat_t                   stat_o,
    output logic [bhpq_pkg::STATUS_W-1:0]          m_status,
    output logic signed [bhpq_pkg::VALUE_W-1:0]    m_top_value,
    output logic                                   m_top_valid,
    output logic [bhpq_pkg::COUNT_W-1:0]           m_count
);
    import bhpq_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    function automatic logic beats(input logic signed [VALUE_W-1:0] a,
                                   input logic signed [VALUE_W-1:0] b,
                                   input logic                      max_mode);
        return max_mode ? (a > b) : (a < b);
    endfunction

    logic signed [VALUE_W-1:0] heap_mem [CAPACITY];

    logic                      max_mode_reg;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic signed [VALUE_W-1:0] val_reg;
    logic signed [VALUE_W-1:0] top_reg;
    logic signed [VALUE_W-1:0] rd_a_reg, rd_b_reg;

    logic [IDX_W-1:0]          idx_m1, parent_idx;
    logic [IDX_W:0]            left_w, right_w, count_x;
    logic [IDX_W-1:0]          addr_a, addr_b;
    logic                      take_right;
    logic signed [VALUE_W-1:0] best_val;
    logic [IDX_W-1:0]          best_idx;
    logic                      we;
    logic signed [VALUE_W-1:0] wdata;

    function automatic logic waddr_is_root();
        return idx_reg == '0;
    endfunction

    assign idx_m1     = idx_reg - 1'b1;
    assign parent_idx = idx_m1 >> 1;
    assign left_w     = {idx_reg, 1'b1};
    assign right_w    = left_w + 1'b1;
    assign count_x    = (IDX_W+1)'(count_reg);

    always_comb begin
        case (cmd_i.rd_sel)
            RD_LAST:   addr_a = count_reg[IDX_W-1:0];
            RD_PARENT: addr_a = parent_idx;
            RD_CHILD:  addr_a = left_w[IDX_W-1:0];
            default:   addr_a = left_w[IDX_W-1:0];
        endcase
    end
    assign addr_b = right_w[IDX_W-1:0];

    // The right child only counts when it exists and strictly beats the left.
    assign take_right = (right_w < count_x) && beats(rd_b_reg, rd_a_reg, max_mode_reg);
    assign best_val   = take_right ? rd_b_reg : rd_a_reg;
    assign best_idx   = take_right ? right_w[IDX_W-1:0] : left_w[IDX_W-1:0];

    assign stat_o.full     = (count_reg == CNT_W'(CAPACITY));
    assign stat_o.empty    = (count_reg == '0);
    assign stat_o.idx_zero = (idx_reg == '0);
    assign stat_o.up_win   = beats(val_reg, rd_a_reg, max_mode_reg);
    assign stat_o.dn_leaf  = (left_w >= count_x);
    assign stat_o.dn_win   = beats(best_val, val_reg, max_mode_reg);

    assign we = cmd_i.up_move | cmd_i.dn_move | cmd_i.place;
    always_comb begin
        if (cmd_i.up_move) begin
            wdata = rd_a_reg;
        end else if (cmd_i.dn_move) begin
            wdata = best_val;
        end else begin
            wdata = val_reg;
        end
    end

    always_comb begin
        count_next = count_reg;
        if (cmd_i.start_push) begin
            count_next = count_reg + 1'b1;
        end else if (cmd_i.start_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb begin
        idx_next = idx_reg;
        if (cmd_i.start_push) begin
            idx_next = count_reg[IDX_W-1:0];
        end else if (cmd_i.start_pop) begin
            idx_next = '0;
        end else if (cmd_i.up_move) begin
            idx_next = parent_idx;
        end else if (cmd_i.dn_move) begin
            idx_next = best_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_mode_reg <= RESET_MAX_MODE;
            count_reg    <= '0;
        end else begin
            if (cfg_valid) begin
                max_mode_reg <= cfg_max_mode;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (cmd_i.start_push) begin
            val_reg <= s_value;
        end else if (cmd_i.load_last) begin
            val_reg <= rd_a_reg;
        end
        if (we && waddr_is_root()) begin
            top_reg <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            heap_mem[idx_reg] <= wdata;
        end
        rd_a_reg <= heap_mem[addr_a];
        rd_b_reg <= heap_mem[addr_b];
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.load_result) begin
            m_status    <= cmd_i.res_status;
            m_top_valid <= (count_reg != '0);
            m_top_value <= (count_reg != '0) ? top_reg : '0;
            m_count     <= COUNT_W'(count_reg);
        end
    end

    `BHPQ_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `BHPQ_ASSERT_SAME(a_push_room, aclk, aresetn, cmd_i.start_push, !stat_o.full)
    `BHPQ_ASSERT_SAME(a_down_only_on_win, aclk, aresetn, cmd_i.dn_move, stat_o.dn_win)
    `BHPQ_ASSERT_NEXT(a_root_copy, aclk, aresetn, we && (idx_reg == '0), top_reg == $past(wdata))

endmodule

### sv/bhpq_ctrl.sv
// ----------------------------------------------------------------------------
// Binary heap controller
// Sequences push sift-up and pop sift-down and hands out one result per item.
// ----------------------------------------------------------------------------
module bhpq_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_op,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  bhpq_pkg::bhpq_stat_t  stat_i,
    output bhpq_pkg::bhpq_cmd_t   cmd_o
);
    import bhpq_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_RD,
        S_POP_LD,
        S_UP_CHK,
        S_UP_CMP,
        S_DN_CHK,
        S_DN_CMP,
        S_FIN
    } state_t;

    state_t  state_reg, state_next;
    status_t res_st_reg, res_st_next;
    logic    m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        res_st_next  = res_st_reg;
        cmd_o        = '0;
        cmd_o.rd_sel = RD_CHILD;
        cmd_o.res_status = res_st_reg;
        m_valid_next = m_valid_reg && !m_ready;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    res_st_next = ST_OK;
                    if (s_op == OP_PUSH) begin
                        if (stat_i.full) begin
                            res_st_next = ST_FULL;
                            state_next  = S_FIN;
                        end else begin
                            cmd_o.start_push = 1'b1;
                            state_next       = S_UP_CHK;
                        end
                    end else begin
                        if (stat_i.empty) begin
                            res_st_next = ST_EMPTY;
                            state_next  = S_FIN;
                        end else begin
                            cmd_o.start_pop = 1'b1;
                            state_next      = S_POP_RD;
                        end
                    end
                end
            end
            S_POP_RD: begin
                // The count is already decremented, so it addresses the last element.
                cmd_o.rd_sel = RD_LAST;
                state_next   = stat_i.empty ? S_FIN : S_POP_LD;
            end
            S_POP_LD: begin
                cmd_o.load_last = 1'b1;
                state_next      = S_DN_CHK;
            end
            S_UP_CHK: begin
                cmd_o.rd_sel = RD_PARENT;
                if (stat_i.idx_zero) begin
                    cmd_o.place = 1'b1;
                    state_next  = S_FIN;
                end else begin
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (stat_i.up_win) begin
                    cmd_o.up_move = 1'b1;
                    state_next    = S_UP_CHK;
                end else begin
                    cmd_o.place = 1'b1;
                    state_next  = S_FIN;
                end
            end
            S_DN_CHK: begin
                cmd_o.rd_sel = RD_CHILD;
                if (stat_i.dn_leaf) begin
                    cmd_o.place = 1'b1;
                    state_next  = S_FIN;
                end else begin
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                if (stat_i.dn_win) begin
                    cmd_o.dn_move = 1'b1;
                    state_next    = S_DN_CHK;
                end else begin
                    cmd_o.place = 1'b1;
                    state_next  = S_FIN;
                end
            end
            S_FIN: begin
                // The result register is free once the previous item is taken.
                if (!m_valid_reg || m_ready) begin
                    cmd_o.load_result = 1'b1;
                    m_valid_next      = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            res_st_reg  <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            res_st_reg  <= res_st_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### dv/tb_binary_heap_priority_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Binary heap priority queue testbench
// Pushes and pops items through the heap under both orderings. A directed
// table covers the value extremes, full and empty rejects and ties. Random
// bursts that lean toward filling or draining follow, under several idle
// patterns. Results match typed table rows or else a local heap model.
// ----------------------------------------------------------------------------
module tb_binary_heap_priority_queue;
    import bhpq_pkg::*;

    localparam int HEAP_DEPTH   = DEFAULT_CAPACITY;
    localparam int LIMIT_CYCLES = 300000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 66;
    localparam int DIR_ROWS     = 20;

    typedef struct packed {
        status_t                    status;
        logic signed [VALUE_W-1:0]  top_value;
        logic                       top_valid;
        logic [COUNT_W-1:0]         count;
    } heap_result_t;

    typedef struct packed {
        logic                       op;
        logic signed [VALUE_W-1:0]  value;
        logic                       rnd;
        logic [7:0]                 reps;
        logic                       typed;
        heap_result_t               exp;
    } dir_row_t;

    localparam heap_result_t NO_EXP = '{ST_OK, 32'sd0, 1'b0, 7'd0};

    // Rows with typed results can be read straight off the heap rules.
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        '{OP_POP,  32'sd0,          1'b0, 8'd1,  1'b1, '{ST_EMPTY, 32'sd0, 1'b0, 7'd0}},
        '{OP_PUSH, 32'sh7FFFFFFF,   1'b0, 8'd1,  1'b1, '{ST_OK, 32'sh7FFFFFFF, 1'b1, 7'd1}},
        '{OP_PUSH, 32'sh80000000,   1'b0, 8'd1,  1'b1, '{ST_OK, 32'sh7FFFFFFF, 1'b1, 7'd2}},
        '{OP_POP,  32'sd0,          1'b0, 8'd1,  1'b1, '{ST_OK, 32'sh80000000, 1'b1, 7'd1}},
        '{OP_POP,  32'sd0,          1'b0, 8'd1,  1'b1, '{ST_OK, 32'sd0, 1'b0, 7'd0}},
        '{OP_POP,  32'sh7FFFFFFF,   1'b0, 8'd1,  1'b1, '{ST_EMPTY, 32'sd0, 1'b0, 7'd0}},
        '{OP_PUSH, -32'sd1,         1'b0, 8'd1,  1'b0, NO_EXP},
        '{OP_PUSH, 32'sd0,          1'b0, 8'd1,  1'b0, NO_EXP},
        '{OP_PUSH, 32'sd1,          1'b0, 8'd1,  1'b0, NO_EXP},
        '{OP_PUSH, 32'sd1,          1'b0, 8'd1,  1'b0, NO_EXP},
        '{OP_PUSH, 32'sh55555555,   1'b0, 8'd1,  1'b0, NO_EXP},
        '{OP_PUSH, 32'shAAAAAAAA,   1'b0, 8'd1,  1'b0, NO_EXP},
        '{OP_POP,  -32'sd1,         1'b0, 8'd1,  1'b0, NO_EXP},
        '{OP_POP,  32'sd0,          1'b0, 8'd1,  1'b0, NO_EXP},
        '{OP_PUSH, 32'sd0,          1'b1, 8'd68, 1'b0, NO_EXP},
        '{OP_PUSH, 32'sh7FFFFFFF,   1'b0, 8'd1,  1'b0, NO_EXP},
        '{OP_POP,  32'sd0,          1'b1, 8'd70, 1'b0, NO_EXP},
        '{OP_PUSH, 32'sh12345678,   1'b0, 8'd1,  1'b1, '{ST_OK, 32'sh12345678, 1'b1, 7'd1}},
        '{OP_PUSH, 32'sh80000000,   1'b0, 8'd1,  1'b1, '{ST_OK, 32'sh12345678, 1'b1, 7'd2}},
        '{OP_PUSH, 32'sd0,          1'b1, 8'd10, 1'b0, NO_EXP}
    };

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic                       cfg_max_mode = RESET_MAX_MODE;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic                       s_op = OP_PUSH;
    logic signed [VALUE_W-1:0]  s_value = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [STATUS_W-1:0]        m_status;
    logic signed [VALUE_W-1:0]  m_top_value;
    logic                       m_top_valid;
    logic [COUNT_W-1:0]         m_count;

    // Model of the heap contents and ordering.
    logic signed [VALUE_W-1:0]  heap_mem [HEAP_DEPTH];
    int                         heap_fill = 0;
    logic                       heap_max = RESET_MAX_MODE;

    heap_result_t               pending_results [$];
    logic                       item_typed = 1'b0;
    heap_result_t               item_exp = NO_EXP;
    int                         n_accepted = 0;
    int                         n_cfg_writes = 0;
    int                         n_fail = 0;
    int                         cycle_cnt = 0;
    int                         send_idle_pct = 0;
    int                         recv_stall_pct = 0;

    binary_heap_priority_queue #(
        .CAPACITY    (HEAP_DEPTH)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_max_mode(cfg_max_mode),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_top_value (m_top_value),
        .m_top_valid (m_top_valid),
        .m_count     (m_count)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic outranks(logic signed [VALUE_W-1:0] a,
                                      logic signed [VALUE_W-1:0] b);
        return heap_max ? (a > b) : (a < b);
    endfunction

    function automatic void heap_swap(int i, int j);
        logic signed [VALUE_W-1:0] t;
        t = heap_mem[i];
        heap_mem[i] = heap_mem[j];
        heap_mem[j] = t;
    endfunction

    // Applies one operation to the model and returns the result it yields.
    function automatic heap_result_t apply_heap_op(logic op, logic signed [VALUE_W-1:0] v);
        heap_result_t res;
        int           idx;
        int           par;
        int           lc;
        int           pick;
        res.status = ST_OK;
        if (op == OP_PUSH) begin
            if (heap_fill >= HEAP_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                heap_mem[heap_fill] = v;
                heap_fill++;
                idx = heap_fill - 1;
                while (idx > 0) begin
                    par = (idx - 1) / 2;
                    if (!outranks(heap_mem[idx], heap_mem[par]))
                        break;
                    heap_swap(idx, par);
                    idx = par;
                end
            end
        end else begin
            if (heap_fill == 0) begin
                res.status = ST_EMPTY;
            end else begin
                heap_fill--;
                heap_mem[0] = heap_mem[heap_fill];
                idx = 0;
                while (1) begin
                    lc = 2 * idx + 1;
                    if (lc >= heap_fill)
                        break;
                    pick = lc;
                    if (lc + 1 < heap_fill && outranks(heap_mem[lc + 1], heap_mem[lc]))
                        pick = lc + 1;
                    if (!outranks(heap_mem[pick], heap_mem[idx]))
                        break;
                    heap_swap(idx, pick);
                    idx = pick;
                end
            end
        end
        res.top_valid = (heap_fill > 0);
        res.top_value = (heap_fill > 0) ? heap_mem[0] : '0;
        res.count     = COUNT_W'(heap_fill);
        return res;
    endfunction

    // Extremes and a narrow band of small values come up often, so ties are common.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2, 3, 4: return VALUE_W'(int'($urandom_range(8)) - 4);
            5: return '0;
            default: return $urandom;
        endcase
    endfunction

    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        heap_result_t got;
        heap_result_t want;
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("[FAIL] regression broken");
            $finish;
        end
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                heap_max = cfg_max_mode;
                n_cfg_writes++;
            end
            if (m_valid && m_ready) begin
                got = '{status_t'(m_status), m_top_value, m_top_valid, m_count};
                if (pending_results.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("unexpected result: status %0d top %0d valid %0b count %0d",
                                 got.status, got.top_value, got.top_valid, got.count);
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        n_fail++;
                        if (n_fail <= 10) begin
                            $display("mismatch: expected status %0d top %0d valid %0b count %0d",
                                     want.status, want.top_value, want.top_valid, want.count);
                            $display("          got status %0d top %0d valid %0b count %0d",
                                     got.status, got.top_value, got.top_valid, got.count);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                want = apply_heap_op(s_op, s_value);
                pending_results = {pending_results, (item_typed ? item_exp : want)};
                n_accepted++;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(logic op, logic signed [VALUE_W-1:0] v,
                             logic typed, heap_result_t exp);
        int start;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid    = 1'b1;
        s_op       = op;
        s_value    = v;
        item_typed = typed;
        item_exp   = exp;
        start      = n_accepted;
        do @(negedge aclk); while (n_accepted == start);
    endtask

    task automatic set_heap_order(logic max_order);
        int start;
        while (pending_results.size() != 0)
            @(negedge aclk);
        cfg_valid    = 1'b1;
        cfg_max_mode = max_order;
        start        = n_cfg_writes;
        do @(negedge aclk); while (n_cfg_writes == start);
        cfg_valid = 1'b0;
    endtask

    // Bursts lean toward filling, draining or a balanced mix so both full and
    // empty heaps are reached often.
    task automatic run_random(int n);
        int left;
        int burst;
        int push_pct;
        left = n;
        while (left > 0) begin
            burst = $urandom_range(48, 16);
            case ($urandom_range(2))
                0: push_pct = 85;
                1: push_pct = 15;
                default: push_pct = 50;
            endcase
            repeat (burst) begin
                if (left > 0) begin
                    send_item(($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP,
                              pick_value(), 1'b0, NO_EXP);
                    left--;
                end
            end
        end
        s_valid = 1'b0;
    endtask

    initial begin
        int send_pat [4];
        int recv_pat [4];
        send_pat = '{0, 53, 0, 33};
        recv_pat = '{0, 0, 53, 33};
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        set_heap_order(1'b1);
        foreach (DIR_TABLE[r]) begin
            for (int k = 0; k < DIR_TABLE[r].reps; k++)
                send_item(DIR_TABLE[r].op,
                          DIR_TABLE[r].rnd ? pick_value() : DIR_TABLE[r].value,
                          DIR_TABLE[r].typed, DIR_TABLE[r].exp);
        end
        s_valid = 1'b0;

        // The first switch to min order happens with elements still held.
        for (int p = 0; p < RAND_PHASES; p++) begin
            set_heap_order(p[0]);
            send_idle_pct  = send_pat[p % 4];
            recv_stall_pct = recv_pat[p % 4];
            run_random(PHASE_ITEMS);
        end

        while (pending_results.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (n_fail == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### binary_heap_priority_queue.f
+incdir+sv
sv/bhpq_pkg.sv
sv/bhpq_datapath.sv
sv/bhpq_ctrl.sv
sv/binary_heap_priority_queue.sv
dv/tb_binary_heap_priority_queue.sv
